/* rtl/core/chs_pkg.sv */
// Shared types, constants and tables for the cosine hemisphere sampler.
package chs_pkg;

    localparam int QBITS     = 17;
    localparam int SQRT_STEPS = 16;

    localparam logic [29:0] PI4_Q30  = 30'd843314857;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;

    localparam logic [1:0] OP_FRONT  = 2'd0;
    localparam logic [1:0] OP_ANGLE  = 2'd1;
    localparam logic [1:0] OP_SCALE  = 2'd2;
    localparam logic [1:0] OP_SQUARE = 2'd3;

    typedef struct packed {
        logic               orig;
        logic [15:0]        r;
        logic               neg;
        logic [1:0]         base;
        logic [31:0]        rem;
        logic [16:0]        q;
        logic [1:0]         quad;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [32:0] cz;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        v;
        logic [31:0]        res;
    } pipe_t;

    function automatic logic [30:0] atan_q30(input int i);
        logic [30:0] a;
        begin
            case (i)
                0:  a = 31'd843314857;
                1:  a = 31'd497837829;
                2:  a = 31'd263043837;
                3:  a = 31'd133525159;
                4:  a = 31'd67021687;
                5:  a = 31'd33543516;
                6:  a = 31'd16775851;
                7:  a = 31'd8388437;
                8:  a = 31'd4194283;
                9:  a = 31'd2097149;
                10: a = 31'd1048576;
                11: a = 31'd524288;
                12: a = 31'd262144;
                13: a = 31'd131072;
                14: a = 31'd65536;
                15: a = 31'd32768;
                16: a = 31'd16384;
                17: a = 31'd8192;
                18: a = 31'd4096;
                19: a = 31'd2048;
                20: a = 31'd1024;
                21: a = 31'd512;
                22: a = 31'd256;
                23: a = 31'd128;
                default: a = 31'd0;
            endcase
            atan_q30 = a;
        end
    endfunction

endpackage

/* rtl/core/chs_aux_cell.sv */
// Single pipeline cell for region select, angle scaling, radius scaling and squaring.
module chs_aux_cell #(
    parameter logic [1:0] OP = 2'd0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  chs_pkg::pipe_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output chs_pkg::pipe_t  out_data
);

    logic           valid_reg;
    chs_pkg::pipe_t data_reg;
    chs_pkg::pipe_t data_next;

    logic signed [16:0] sx, sy, nsx, nsy, num;
    logic [15:0]        mag;
    logic signed [18:0] qs;
    logic [18:0]        theta;
    logic [46:0]        aprod;
    logic signed [32:0] sn, cs;
    logic signed [50:0] px, py;
    logic signed [50:0] rx, ry;
    logic signed [31:0] sqx, sqy;
    logic signed [33:0] sum;

    function automatic logic signed [15:0] sat16(input logic signed [50:0] p);
        begin
            if (p > 51'sd32767)
                sat16 = 16'sh7FFF;
            else if (p < -51'sd32768)
                sat16 = -16'sh8000;
            else
                sat16 = p[15:0];
        end
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        sx  = {in_data.x[15], in_data.x};
        sy  = {in_data.y[15], in_data.y};
        nsx = -sx;
        nsy = -sy;
        num = '0;
        mag = '0;
        qs = '0;
        theta = '0;
        aprod = '0;
        sn = '0;
        cs = '0;
        px = '0;
        py = '0;
        rx = '0;
        ry = '0;
        sqx = '0;
        sqy = '0;
        sum = '0;
        case (OP)
            chs_pkg::OP_FRONT:
            begin
                if (sx >= nsy)
                begin
                    if (sx > sy)
                    begin
                        data_next.r = sx[15:0]; num = sy;
                        data_next.neg = 1'b0; data_next.base = 2'd0;
                    end
                    else
                    begin
                        data_next.r = sy[15:0]; num = sx;
                        data_next.neg = 1'b1; data_next.base = 2'd1;
                    end
                end
                else
                begin
                    if (sx <= sy)
                    begin
                        data_next.r = nsx[15:0]; num = sy;
                        data_next.neg = 1'b1; data_next.base = 2'd2;
                    end
                    else
                    begin
                        data_next.r = nsy[15:0]; num = sx;
                        data_next.neg = 1'b0; data_next.base = 2'd3;
                    end
                end
                mag = num[16] ? 16'(-num) : num[15:0];
                data_next.neg  = data_next.neg ^ num[16];
                data_next.rem  = {mag, 16'd0};
                data_next.q    = '0;
                data_next.orig = (sx == 17'sd0) && (sy == 17'sd0);
            end
            chs_pkg::OP_ANGLE:
            begin
                qs = in_data.neg ? -$signed({2'b00, in_data.q}) : $signed({2'b00, in_data.q});
                theta = {in_data.base, 17'd0} + 19'(qs);
                aprod = 47'(theta[16:0]) * 47'(chs_pkg::PI4_Q30);
                data_next.quad = theta[18:17];
                data_next.cz = $signed({2'b00, aprod[46:16]});
                data_next.cx = $signed({3'b000, chs_pkg::GAIN_Q30});
                data_next.cy = '0;
            end
            chs_pkg::OP_SCALE:
            begin
                case (in_data.quad)
                    2'd0: begin sn = in_data.cy;  cs = in_data.cx;  end
                    2'd1: begin sn = in_data.cx;  cs = -in_data.cy; end
                    2'd2: begin sn = -in_data.cy; cs = -in_data.cx; end
                    default: begin sn = -in_data.cx; cs = in_data.cy; end
                endcase
                px = $signed({35'd0, in_data.r}) * 51'(sn);
                py = $signed({35'd0, in_data.r}) * 51'(cs);
                rx = (px + 51'sd536870912) >>> 30;
                ry = (py + 51'sd536870912) >>> 30;
                data_next.x = in_data.orig ? 16'sd0 : sat16(rx);
                data_next.y = in_data.orig ? 16'sd0 : sat16(ry);
            end
            default:
            begin
                sqx = in_data.x * in_data.x;
                sqy = in_data.y * in_data.y;
                sum = $signed({3'b000, chs_pkg::ONE_Q30}) - 34'(sqx) - 34'(sqy);
                data_next.v   = (sum > 34'sd0) ? sum[31:0] : 32'd0;
                data_next.res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* rtl/core/chs_div_cell.sv */
// Restoring division cell: one quotient bit per cell.
module chs_div_cell #(
    parameter int BIT = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  chs_pkg::pipe_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output chs_pkg::pipe_t  out_data
);

    logic           valid_reg;
    chs_pkg::pipe_t data_reg;
    chs_pkg::pipe_t data_next;
    logic [32:0]    sh;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        sh = {17'd0, in_data.r} << BIT;
        if ({1'b0, in_data.rem} >= sh)
        begin
            data_next.rem    = in_data.rem - sh[31:0];
            data_next.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* rtl/core/chs_cordic_cell.sv */
// CORDIC rotation cell: one micro-rotation per cell.
module chs_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  chs_pkg::pipe_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output chs_pkg::pipe_t  out_data
);

    localparam logic signed [32:0] ANG = $signed({2'b00, chs_pkg::atan_q30(STEP)});

    logic               valid_reg;
    chs_pkg::pipe_t     data_reg;
    chs_pkg::pipe_t     data_next;
    logic signed [32:0] dx, dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        dx = in_data.cy >>> STEP;
        dy = in_data.cx >>> STEP;
        if (!in_data.cz[32])
        begin
            data_next.cx = in_data.cx - dx;
            data_next.cy = in_data.cy + dy;
            data_next.cz = in_data.cz - ANG;
        end
        else
        begin
            data_next.cx = in_data.cx + dx;
            data_next.cy = in_data.cy - dy;
            data_next.cz = in_data.cz + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* rtl/core/chs_sqrt_cell.sv */
// Integer square root cell: one result bit per cell.
module chs_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  chs_pkg::pipe_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output chs_pkg::pipe_t  out_data
);

    localparam logic [31:0] BITV = 32'd1 << (30 - 2 * STEP);

    logic           valid_reg;
    chs_pkg::pipe_t data_reg;
    chs_pkg::pipe_t data_next;
    logic [31:0]    trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        trial = in_data.res + BITV;
        if (in_data.v >= trial)
        begin
            data_next.v   = in_data.v - trial;
            data_next.res = (in_data.res >> 1) + BITV;
        end
        else
        begin
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* rtl/core/cosine_hemisphere_sample_unit.sv */
// Top level of the cosine-weighted hemisphere direction sampler.
//   channel  dir  width  fields (low bit first)
//   s_*      in   32     u_first[15:0], u_second[31:16]
//   m_*      out  48     dir_x[15:0], dir_y[31:16], dir_z[46:32], zero
// One item per cycle while m_tready is held high.
// Every cell holds one item; the chain of cells sets the latency.
// A stalled output backs the chain up cell by cell; bubbles are squeezed out.
// Reset clears the valid bit of every cell.
module cosine_hemisphere_sample_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // u_first, u_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // dir_x, dir_y, dir_z, pad
);

    localparam int DIV0 = 1;
    localparam int ANG  = DIV0 + chs_pkg::QBITS;
    localparam int COR0 = ANG + 1;
    localparam int SCL  = COR0 + CORDIC_STEPS;
    localparam int SQR  = SCL + 1;
    localparam int RT0  = SQR + 1;
    localparam int NS   = RT0 + chs_pkg::SQRT_STEPS;

    chs_pkg::pipe_t pd [0:NS];
    logic           pv [0:NS];
    logic           pr [0:NS];
    logic [14:0]    dir_z;

    always_comb
    begin
        pd[0]   = '0;
        pd[0].x = $signed(s_tdata[15:0] ^ 16'h8000);
        pd[0].y = $signed(s_tdata[31:16] ^ 16'h8000);
    end
    assign pv[0]    = s_tvalid;
    assign s_tready = pr[0];

    chs_aux_cell #(.OP(chs_pkg::OP_FRONT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv[0]), .in_ready(pr[0]), .in_data(pd[0]),
        .out_valid(pv[1]), .out_ready(pr[1]), .out_data(pd[1])
    );

    for (genvar k = 0; k < chs_pkg::QBITS; k++)
    begin : g_div
        chs_div_cell #(.BIT(chs_pkg::QBITS - 1 - k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(pv[DIV0 + k]), .in_ready(pr[DIV0 + k]), .in_data(pd[DIV0 + k]),
            .out_valid(pv[DIV0 + k + 1]), .out_ready(pr[DIV0 + k + 1]),
            .out_data(pd[DIV0 + k + 1])
        );
    end

    chs_aux_cell #(.OP(chs_pkg::OP_ANGLE)) u_angle (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv[ANG]), .in_ready(pr[ANG]), .in_data(pd[ANG]),
        .out_valid(pv[ANG + 1]), .out_ready(pr[ANG + 1]), .out_data(pd[ANG + 1])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        chs_cordic_cell #(.STEP(k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(pv[COR0 + k]), .in_ready(pr[COR0 + k]), .in_data(pd[COR0 + k]),
            .out_valid(pv[COR0 + k + 1]), .out_ready(pr[COR0 + k + 1]),
            .out_data(pd[COR0 + k + 1])
        );
    end

    chs_aux_cell #(.OP(chs_pkg::OP_SCALE)) u_scale (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv[SCL]), .in_ready(pr[SCL]), .in_data(pd[SCL]),
        .out_valid(pv[SCL + 1]), .out_ready(pr[SCL + 1]), .out_data(pd[SCL + 1])
    );

    chs_aux_cell #(.OP(chs_pkg::OP_SQUARE)) u_square (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv[SQR]), .in_ready(pr[SQR]), .in_data(pd[SQR]),
        .out_valid(pv[SQR + 1]), .out_ready(pr[SQR + 1]), .out_data(pd[SQR + 1])
    );

    for (genvar k = 0; k < chs_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        chs_sqrt_cell #(.STEP(k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(pv[RT0 + k]), .in_ready(pr[RT0 + k]), .in_data(pd[RT0 + k]),
            .out_valid(pv[RT0 + k + 1]), .out_ready(pr[RT0 + k + 1]),
            .out_data(pd[RT0 + k + 1])
        );
    end

    assign dir_z    = (pd[NS].res > 32'd32767) ? 15'h7FFF : pd[NS].res[14:0];
    assign m_tvalid = pv[NS];
    assign pr[NS]   = m_tready;
    assign m_tdata  = {1'b0, dir_z, pd[NS].y, pd[NS].x};

    logic signed [31:0] chk_r2;
    assign chk_r2 = (pd[NS].x * pd[NS].x) + (pd[NS].y * pd[NS].y);

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with output free");

    a_origin_top: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && pd[NS].x == 16'sd0 && pd[NS].y == 16'sd0) |-> dir_z == 15'h7FFF)
        else $error("zero x and y without full z");

    a_z_zero_on_rim: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && dir_z == 15'd0) |-> chk_r2 >= 32'sd1073741824)
        else $error("z is zero inside the unit disc");

endmodule
